// ===== rtl/double_ended_queue_unit_assert.svh =====
// assertion macros for the double ended queue unit
// depends on nothing; included by the top level only
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DEQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque assertion failed");
// next-cycle implication
`define DEQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque assertion failed");
`else
`define DEQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DEQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/deq_pkg.sv =====
// shared constants, codes and controller/datapath interface types
// for the double ended queue unit; no dependencies
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_REAR   = 3'd3;
    localparam logic [2:0] OP_LIST       = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       push_front;
        logic       push_rear;
        logic       pop_front;
        logic       pop_rear;
        logic       list_start;
        logic       list_next;
        logic       load;
        logic [1:0] status;
        logic       use_ram;
        logic       last;
    } deq_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic list_last;
        logic out_free;
    } deq_stat_t;

    function automatic idx_t wrap_inc(input idx_t i);
        return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + idx_t'(1));
    endfunction

    function automatic idx_t wrap_dec(input idx_t i);
        return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - idx_t'(1));
    endfunction

endpackage

// ===== rtl/double_ended_queue_unit.sv =====
// top level of the double ended queue unit: controller plus datapath
// depends on deq_pkg, deq_ctrl, deq_datapath and the assertion header
//
//  channel   direction   handshake              payload
//  input     in          in_valid / in_stall    op, value
//  output    out         out_valid / out_stall  status, item, last
//
// pushes and refused or empty requests go from acceptance straight into
// the output register; a pop first reads the storage ram, whose read port
// is registered, and then loads its result into the output register
// a listing of n entries gives one result per cycle while the output does not
// stall, after a read start that the registered ram read port makes necessary
// reset clears pointers, fill count and control; storage is not cleared
// out_stall holds the output register and stalls the input side and any
// listing in progress until the result is taken
`include "double_ended_queue_unit_assert.svh"

module double_ended_queue_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         op,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] item,
    output logic               last
);
    import deq_pkg::*;

    // command and status bundles between controller and datapath
    deq_cmd_t  cmd;
    deq_stat_t stat;

    // accepted input transaction
    logic in_acc;
    assign in_acc = in_valid && !in_stall;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .stat     (stat),
        .cmd      (cmd)
    );

    deq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .item      (item),
        .last      (last)
    );

    // the fill count can never report full and empty together
    `DEQ_ASSERT_IMP(a_full_empty, clk, rst_n, stat.full, !stat.empty)
    // a push always yields its single result on the next cycle
    `DEQ_ASSERT_NXT(a_push_result, clk, rst_n,
        in_acc && (op == OP_PUSH_FRONT || op == OP_PUSH_REAR), out_valid && last)
    // refused and empty results carry a zero item and end the transaction
    `DEQ_ASSERT_IMP(a_err_zero, clk, rst_n,
        out_valid && status != STAT_OK, item == 32'sd0 && last)
    // a pop from a non-empty queue keeps the input stalled while it reads
    `DEQ_ASSERT_NXT(a_pop_busy, clk, rst_n,
        in_acc && !stat.empty && (op == OP_POP_FRONT || op == OP_POP_REAR), in_stall)

endmodule

// ===== rtl/deq_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/deq_datapath.sv =====
// ring pointers, fill count, storage ram and output register
// depends on deq_pkg and deq_ram
module deq_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  deq_pkg::deq_cmd_t      cmd,
    output deq_pkg::deq_stat_t     stat,
    input  logic signed [31:0]     value,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             status,
    output logic signed [31:0]     item,
    output logic                   last
);
    import deq_pkg::*;

    idx_t front_reg, front_next;
    idx_t rear_reg, rear_next;
    cnt_t count_reg, count_next;
    idx_t list_addr_reg, list_addr_next;
    cnt_t list_rem_reg, list_rem_next;

    logic              wr_en;
    idx_t              wr_addr;
    logic              rd_en;
    idx_t              rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [DATA_W-1:0] item_reg;
    logic              last_reg;

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        front_next     = front_reg;
        rear_next      = rear_reg;
        count_next     = count_reg;
        list_addr_next = list_addr_reg;
        list_rem_next  = list_rem_reg;
        wr_en          = cmd.push_front || cmd.push_rear;
        wr_addr        = cmd.push_front ? wrap_dec(front_reg) : rear_reg;
        rd_en          = cmd.pop_front || cmd.pop_rear || cmd.list_start || cmd.list_next;
        rd_addr        = front_reg;

        if (cmd.push_front)
        begin
            front_next = wrap_dec(front_reg);
            count_next = cnt_t'(count_reg + cnt_t'(1));
        end
        if (cmd.push_rear)
        begin
            rear_next  = wrap_inc(rear_reg);
            count_next = cnt_t'(count_reg + cnt_t'(1));
        end
        if (cmd.pop_front || cmd.pop_rear)
        begin
            count_next = cnt_t'(count_reg - cnt_t'(1));
            if (cmd.pop_front)
            begin
                front_next = wrap_inc(front_reg);
            end
            else
            begin
                rd_addr   = wrap_dec(rear_reg);
                rear_next = wrap_dec(rear_reg);
            end
            // queue drained: pointers go home
            if (count_reg == cnt_t'(1))
            begin
                front_next = '0;
                rear_next  = '0;
            end
        end
        if (cmd.list_start)
        begin
            list_addr_next = wrap_inc(front_reg);
            list_rem_next  = count_reg;
        end
        if (cmd.list_next)
        begin
            rd_addr        = list_addr_reg;
            list_addr_next = wrap_inc(list_addr_reg);
            list_rem_next  = cnt_t'(list_rem_reg - cnt_t'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            rear_reg      <= '0;
            count_reg     <= '0;
            list_addr_reg <= '0;
            list_rem_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            count_reg     <= count_next;
            list_addr_reg <= list_addr_next;
            list_rem_reg  <= list_rem_next;
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg <= cmd.status;
            item_reg   <= cmd.use_ram ? rd_data : '0;
            last_reg   <= cmd.last;
        end
    end

    assign stat.full      = (count_reg == cnt_t'(DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.list_last = (list_rem_reg == cnt_t'(1));
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign item      = signed'(item_reg);
    assign last      = last_reg;

endmodule

// ===== rtl/deq_ctrl.sv =====
// controller state machine: decodes ops and sequences pops and listings
// depends on deq_pkg
module deq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         op,
    input  deq_pkg::deq_stat_t stat,
    output deq_pkg::deq_cmd_t  cmd
);
    import deq_pkg::*;

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_POP_OUT  = 2'd1;
    localparam logic [1:0] S_LIST_OUT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign in_stall = (state_reg != S_IDLE) || !stat.out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.status = STAT_OK;
        cmd.last   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_PUSH_FRONT, OP_PUSH_REAR:
                        begin
                            cmd.load = 1'b1;
                            if (stat.full)
                            begin
                                cmd.status = STAT_FULL;
                            end
                            else
                            begin
                                cmd.push_front = (op == OP_PUSH_FRONT);
                                cmd.push_rear  = (op == OP_PUSH_REAR);
                            end
                        end
                        OP_POP_FRONT, OP_POP_REAR:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load   = 1'b1;
                                cmd.status = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.pop_front = (op == OP_POP_FRONT);
                                cmd.pop_rear  = (op == OP_POP_REAR);
                                state_next    = S_POP_OUT;
                            end
                        end
                        OP_LIST:
                        begin
                            if (stat.empty)
                            begin
                                cmd.load   = 1'b1;
                                cmd.status = STAT_EMPTY;
                            end
                            else
                            begin
                                cmd.list_start = 1'b1;
                                state_next     = S_LIST_OUT;
                            end
                        end
                        default:
                        begin
                            // unused codes are dropped
                        end
                    endcase
                end
            end
            S_POP_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load    = 1'b1;
                    cmd.use_ram = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_LIST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load    = 1'b1;
                    cmd.use_ram = 1'b1;
                    cmd.last    = stat.list_last;
                    if (stat.list_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.list_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== test/tb_double_ended_queue_unit.sv =====
// self-checking testbench for double_ended_queue_unit: directed table, then random traffic
// depends on deq_pkg and the rtl top level; predicts every result with a mirror deque
module tb_double_ended_queue_unit;
    import deq_pkg::*;

    // one result transaction as seen on the output channel
    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] item;
        logic               last;
    } deque_result_t;

    // one row of the directed table; want is only used when typed is set
    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] value;
        bit                 typed;
        deque_result_t      want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [2:0]         op;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic signed [31:0] item;
    logic               last;

    // mirror of the deque contents and pointers
    logic signed [31:0] mirror_store [DEPTH];
    idx_t               mirror_front;
    idx_t               mirror_rear;
    cnt_t               mirror_count;

    deque_result_t awaited_results [$];
    stim_row_t     dir_table [$];
    int            error_count;

    // side info for the transaction on the input channel, read on acceptance
    bit            cur_typed;
    deque_result_t cur_want;

    // when set, neither side idles
    bit quiet;

    double_ended_queue_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .item      (item),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    // work out the results of one accepted transaction and update the mirror
    task automatic model_deque_op(input logic [2:0] code, input logic signed [31:0] data);
        deque_result_t r;
        int            n;
        int            k;
        r.status = STAT_OK;
        r.item   = '0;
        r.last   = 1'b1;
        case (code)
            OP_PUSH_FRONT, OP_PUSH_REAR:
            begin
                if (int'(mirror_count) >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    if (code == OP_PUSH_FRONT)
                    begin
                        mirror_front = idx_t'((int'(mirror_front) + DEPTH - 1) % DEPTH);
                        mirror_store[mirror_front] = data;
                    end
                    else
                    begin
                        mirror_store[mirror_rear] = data;
                        mirror_rear = idx_t'((int'(mirror_rear) + 1) % DEPTH);
                    end
                    mirror_count = cnt_t'(mirror_count + 1);
                end
                awaited_results.push_back(r);
            end
            OP_POP_FRONT, OP_POP_REAR:
            begin
                if (mirror_count == '0)
                    r.status = STAT_EMPTY;
                else
                begin
                    if (code == OP_POP_FRONT)
                    begin
                        r.item = mirror_store[mirror_front];
                        mirror_front = idx_t'((int'(mirror_front) + 1) % DEPTH);
                    end
                    else
                    begin
                        mirror_rear = idx_t'((int'(mirror_rear) + DEPTH - 1) % DEPTH);
                        r.item = mirror_store[mirror_rear];
                    end
                    mirror_count = cnt_t'(mirror_count - 1);
                    // an emptied deque returns both pointers to zero
                    if (mirror_count == '0)
                    begin
                        mirror_front = '0;
                        mirror_rear  = '0;
                    end
                end
                awaited_results.push_back(r);
            end
            OP_LIST:
            begin
                if (mirror_count == '0)
                begin
                    r.status = STAT_EMPTY;
                    awaited_results.push_back(r);
                end
                else
                begin
                    n = int'(mirror_count);
                    for (k = 0; k < n; k++)
                    begin
                        r.item = mirror_store[(int'(mirror_front) + k) % DEPTH];
                        r.last = (k == n - 1);
                        awaited_results.push_back(r);
                    end
                end
            end
            default:
            begin
                // unused codes are dropped without a result
            end
        endcase
    endtask

    // predict on input acceptance, check on output acceptance
    always @(posedge clk)
    begin
        deque_result_t exp_r;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                model_deque_op(op, value);
                // a typed table row replaces the single predicted result
                if (cur_typed && op <= OP_LIST)
                    awaited_results[awaited_results.size() - 1] = cur_want;
            end
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result with no expectation: status %0d item %0d last %0d",
                           status, item, last);
                    error_count++;
                end
                else
                begin
                    exp_r = awaited_results.pop_front();
                    if (status !== exp_r.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d", exp_r.status, status);
                        error_count++;
                    end
                    if (item !== exp_r.item)
                    begin
                        $error("item mismatch: expected %0d, actual %0d", exp_r.item, item);
                        error_count++;
                    end
                    if (last !== exp_r.last)
                    begin
                        $error("last mismatch: expected %0d, actual %0d", exp_r.last, last);
                        error_count++;
                    end
                end
            end
        end
    end

    // receiver stalls at random, about 36 percent of the time, outside the quiet stretch
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= !quiet && ($urandom_range(0, 99) < 36);
        end
    end

    function automatic bit idle_now();
        return !quiet && ($urandom_range(0, 99) < 36);
    endfunction

    function automatic stim_row_t mk_row(input logic [2:0] code, input logic signed [31:0] data,
                                         input bit typed, input logic [1:0] st,
                                         input logic signed [31:0] itm);
        stim_row_t row;
        row.op          = code;
        row.value       = data;
        row.typed       = typed;
        row.want.status = st;
        row.want.item   = itm;
        row.want.last   = 1'b1;
        return row;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    // in_valid stays high on return so back-to-back transactions need no re-raise
    task automatic send_txn(input logic [2:0] code, input logic signed [31:0] data,
                            input bit typed, input deque_result_t want);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            op       <= 3'($urandom);
            value    <= $urandom;
            @(negedge clk);
        end
        cur_typed = typed;
        cur_want  = want;
        in_valid <= 1'b1;
        op       <= code;
        value    <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // sender holds off until every awaited result has been taken or the wait limit runs out
    task automatic drain_results(input int limit);
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (awaited_results.size() != 0 && waited < limit);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7fffffff;
            1:       return 32'h80000000;
            2:       return 32'h00000000;
            3:       return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    // op mix shifts between filling, draining and balanced phases
    function automatic logic [2:0] pick_op(input int phase);
        int r;
        int push_lim;
        int pop_lim;
        r = $urandom_range(0, 99);
        case (phase)
            0:       begin push_lim = 70; pop_lim = 88; end
            1:       begin push_lim = 25; pop_lim = 85; end
            default: begin push_lim = 45; pop_lim = 80; end
        endcase
        if (r < 4)
            return 3'($urandom_range(5, 7));
        else if (r < push_lim)
            return $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        else if (r < pop_lim)
            return $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
        else
            return OP_LIST;
    endfunction

    localparam logic [31:0] FILL_PAT [16] = '{
        32'h00000001, 32'h55555555, 32'haaaaaaaa, 32'h0000ffff,
        32'hffff0000, 32'h7ffffffe, 32'h80000001, 32'h12345678,
        32'hfedcba98, 32'h00ff00ff, 32'hff00ff00, 32'h0f0f0f0f,
        32'hf0f0f0f0, 32'h33333333, 32'hcccccccc, 32'h00000000
    };

    initial
    begin
        int            k;
        int            sent;
        bit            paused;
        logic [2:0]    code;
        deque_result_t none;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = '0;
        value        = '0;
        quiet        = 1'b0;
        cur_typed    = 1'b0;
        error_count  = 0;
        mirror_front = '0;
        mirror_rear  = '0;
        mirror_count = '0;
        none.status  = STAT_OK;
        none.item    = '0;
        none.last    = 1'b1;
        cur_want     = none;

        // empty deque: pops and listing report empty
        dir_table.push_back(mk_row(OP_POP_FRONT, 32'h0, 1, STAT_EMPTY, 32'h0));
        dir_table.push_back(mk_row(OP_POP_REAR, 32'hffffffff, 1, STAT_EMPTY, 32'h0));
        dir_table.push_back(mk_row(OP_LIST, 32'h0, 1, STAT_EMPTY, 32'h0));
        // value extremes in at both ends, listed, then out again
        dir_table.push_back(mk_row(OP_PUSH_FRONT, 32'h7fffffff, 1, STAT_OK, 32'h0));
        dir_table.push_back(mk_row(OP_PUSH_REAR, 32'h80000000, 1, STAT_OK, 32'h0));
        dir_table.push_back(mk_row(OP_LIST, 32'h0, 0, STAT_OK, 32'h0));
        dir_table.push_back(mk_row(OP_POP_FRONT, 32'h0, 1, STAT_OK, 32'h7fffffff));
        dir_table.push_back(mk_row(OP_POP_REAR, 32'h0, 1, STAT_OK, 32'h80000000));
        // unused codes give nothing
        dir_table.push_back(mk_row(3'd5, 32'h11111111, 0, STAT_OK, 32'h0));
        dir_table.push_back(mk_row(3'd7, 32'heeeeeeee, 0, STAT_OK, 32'h0));
        // fill from both ends so the front pointer wraps
        for (k = 0; k < DEPTH; k++)
            dir_table.push_back(mk_row(k[0] ? OP_PUSH_REAR : OP_PUSH_FRONT, FILL_PAT[k % 16],
                                       0, STAT_OK, 32'h0));
        // full deque refuses pushes, then a full-length listing
        dir_table.push_back(mk_row(OP_PUSH_REAR, 32'h5a5a5a5a, 1, STAT_FULL, 32'h0));
        dir_table.push_back(mk_row(OP_PUSH_FRONT, 32'ha5a5a5a5, 1, STAT_FULL, 32'h0));
        dir_table.push_back(mk_row(OP_LIST, 32'h0, 0, STAT_OK, 32'h0));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_table[i])
            send_txn(dir_table[i].op, dir_table[i].value, dir_table[i].typed,
                     dir_table[i].want);

        // let the directed part settle before random traffic
        drain_results(100000);

        sent   = 0;
        paused = 1'b0;
        while (sent < 360)
        begin
            quiet = (sent >= 100 && sent < 160);
            if (sent == 220 && !paused)
            begin
                paused = 1'b1;
                drain_results(100000);
            end
            code = pick_op((sent / 30) % 3);
            send_txn(code, pick_value(), 1'b0, none);
            if (code <= OP_LIST)
                sent++;
        end
        quiet = 1'b0;

        drain_results(100000);
        repeat (20) @(posedge clk);

        if (awaited_results.size() != 0)
        begin
            $error("%0d expected results never arrived", awaited_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_datapath.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue_unit.sv
test/tb_double_ended_queue_unit.sv
